// ===== rtl/ett_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ett_pkg;
   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] ACT_ANIMATE = 2'd0;
   localparam logic [1:0] ACT_STOP    = 2'd1;
   localparam logic [1:0] ACT_FRAME   = 2'd2;

   localparam logic [2:0] KIND_ACCEPTED = 3'd0;
   localparam logic [2:0] KIND_FULL     = 3'd1;
   localparam logic [2:0] KIND_STOPPED  = 3'd2;
   localparam logic [2:0] KIND_UPDATE   = 3'd3;
   localparam logic [2:0] KIND_FINISHED = 3'd4;
   localparam logic [2:0] KIND_EMPTY    = 3'd5;

   localparam int FRAC_W = 16;
endpackage
`default_nettype wire

// ===== rtl/eased_tween_table_unit.sv =====
// Eased tween table: up to SLOTS active tweens kept in insertion order.
// Command channel: an item is taken when start is high and busy is low.
// Results come out at most one per cycle on the rsp_ ports, marked by rsp_valid,
// with rsp_last on the final result of an item; the receiver cannot stall.
// animate_to scans the table (one slot per cycle, replacing a matching
// entry), then appends at the tail, or reports full; one result.
// stop_all walks the table newest to oldest, one slot per cycle; one result.
// Frame tick walks the table newest to oldest. A finished entry is handled
// in the check state alone; a running entry goes through the 16-step
// restoring divider for the progress fraction and three passes through
// the shared 34x17 multiplier (cube and scale). One result per entry;
// an empty table gives a single frame-empty result the cycle after accept.
// Removal compacts the table by shifting later entries down.
// Reset empties the table and returns the sequencer to idle; slot contents
// are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module eased_tween_table_unit
   import ett_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_target_id,
   input  wire logic [7:0]  req_property_id,
   input  wire logic signed [31:0] req_current_value,
   input  wire logic signed [31:0] req_goal_value,
   input  wire logic [15:0] req_duration_ms,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_out_target,
   output logic [7:0]       rsp_out_property,
   output logic signed [31:0] rsp_value,
   output logic             rsp_last
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN   = 4'd1;
   localparam logic [3:0] ST_APPEND = 4'd2;
   localparam logic [3:0] ST_STOP   = 4'd3;
   localparam logic [3:0] ST_FCHK   = 4'd4;
   localparam logic [3:0] ST_FDIV   = 4'd5;
   localparam logic [3:0] ST_FMUL1  = 4'd6;
   localparam logic [3:0] ST_FMUL2  = 4'd7;
   localparam logic [3:0] ST_FEXP   = 4'd8;
   localparam logic [3:0] ST_FMUL3  = 4'd9;
   localparam logic [3:0] ST_FOUT   = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [3:0]  step_ff, step_in;

   logic [15:0] tgt_ff;
   logic [7:0]  prop_ff;
   logic [31:0] cur_ff, goal_ff, now_ff;
   logic [15:0] dur_ff;

   logic [15:0] slot_target_ff [SLOTS];
   logic [7:0]  slot_property_ff [SLOTS];
   logic [31:0] slot_start_ff [SLOTS];
   logic [31:0] slot_end_ff [SLOTS];
   logic [31:0] slot_begin_ff [SLOTS];
   logic [15:0] slot_duration_ff [SLOTS];

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [16:0] t_div;
   logic        div_ge;
   logic [50:0] prod_ff;
   logic [33:0] mul_a;
   logic [16:0] mul_b;
   logic [50:0] mul_p;
   logic [16:0] e_ff;
   logic [48:0] e_diff;
   logic [33:0] mag_ff;
   logic        neg_ff;
   logic [32:0] diff;
   logic [33:0] dmag;
   logic [31:0] upd_value;

   logic [IDX_W-1:0] rd_idx;
   logic [15:0] rd_target;
   logic [7:0]  rd_property;
   logic [31:0] rd_start, rd_end, rd_begin;
   logic [15:0] rd_duration;
   logic [31:0] elapsed;
   logic        done_entry;

   logic        rm_en;
   logic        wr_en;
   logic        accept;

   logic        o_valid_in, o_last_in;
   logic [2:0]  o_kind_in;
   logic [15:0] o_tgt_in;
   logic [7:0]  o_prop_in;
   logic [31:0] o_val_in;
   logic        o_valid_ff, o_last_ff;
   logic [2:0]  o_kind_ff;
   logic [15:0] o_tgt_ff;
   logic [7:0]  o_prop_ff;
   logic [31:0] o_val_ff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // scan walks upward from slot zero, stop and frame walk downward
   assign rd_idx = (state_ff == ST_SCAN) ? idx_ff[IDX_W-1:0]
                                         : IDX_W'(idx_ff - CNT_W'(1));
   assign rd_target   = slot_target_ff[rd_idx];
   assign rd_property = slot_property_ff[rd_idx];
   assign rd_start    = slot_start_ff[rd_idx];
   assign rd_end      = slot_end_ff[rd_idx];
   assign rd_begin    = slot_begin_ff[rd_idx];
   assign rd_duration = slot_duration_ff[rd_idx];

   assign elapsed    = now_ff - rd_begin;
   assign done_entry = (rd_duration == 16'd0) || (elapsed >= {16'd0, rd_duration});
   assign diff       = {rd_end[31], rd_end} - {rd_start[31], rd_start};

   assign t_div  = {rem_ff, 1'b0};
   assign div_ge = t_div >= {1'b0, rd_duration};

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_FMUL1: begin
            mul_a = {17'd0, 17'h10000 - {1'b0, quo_ff}};
            mul_b = 17'h10000 - {1'b0, quo_ff};
         end
         ST_FMUL2: begin
            mul_a = prod_ff[33:0];
            mul_b = 17'h10000 - {1'b0, quo_ff};
         end
         default: begin
            mul_a = mag_ff;
            mul_b = e_ff;
         end
      endcase
   end
   assign mul_p = 51'(mul_a * mul_b);

   assign e_diff    = (49'd1 << 48) - prod_ff[48:0];
   assign dmag      = 34'(prod_ff[50:16]);
   assign upd_value = neg_ff ? 32'(rd_start - dmag[31:0]) : 32'(rd_start + dmag[31:0]);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      rm_en      = 1'b0;
      wr_en      = 1'b0;
      o_valid_in = 1'b0;
      o_last_in  = 1'b0;
      o_kind_in  = KIND_ACCEPTED;
      o_tgt_in   = 16'd0;
      o_prop_in  = 8'd0;
      o_val_in   = 32'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_action)
                  ACT_ANIMATE: begin
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
                  ACT_STOP: begin
                     idx_in   = count_ff;
                     state_in = ST_STOP;
                  end
                  ACT_FRAME: begin
                     if (count_ff == '0) begin
                        o_valid_in = 1'b1;
                        o_last_in  = 1'b1;
                        o_kind_in  = KIND_EMPTY;
                     end else begin
                        idx_in   = count_ff;
                        state_in = ST_FCHK;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = ST_APPEND;
            end else if (rd_target == tgt_ff && rd_property == prop_ff) begin
               rm_en    = 1'b1;
               count_in = count_ff - CNT_W'(1);
               state_in = ST_APPEND;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_APPEND: begin
            o_valid_in = 1'b1;
            o_last_in  = 1'b1;
            o_tgt_in   = tgt_ff;
            o_prop_in  = prop_ff;
            if (count_ff >= CNT_W'(SLOTS)) begin
               o_kind_in = KIND_FULL;
            end else begin
               o_kind_in = KIND_ACCEPTED;
               wr_en     = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_STOP: begin
            if (idx_ff == '0) begin
               o_valid_in = 1'b1;
               o_last_in  = 1'b1;
               o_kind_in  = KIND_STOPPED;
               o_tgt_in   = tgt_ff;
               state_in   = ST_IDLE;
            end else begin
               if (rd_target == tgt_ff) begin
                  rm_en    = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
               idx_in = idx_ff - CNT_W'(1);
            end
         end
         ST_FCHK: begin
            if (done_entry) begin
               o_valid_in = 1'b1;
               o_last_in  = (rd_idx == '0);
               o_kind_in  = KIND_FINISHED;
               o_tgt_in   = rd_target;
               o_prop_in  = rd_property;
               o_val_in   = rd_end;
               rm_en      = 1'b1;
               count_in   = count_ff - CNT_W'(1);
               idx_in     = idx_ff - CNT_W'(1);
               state_in   = (rd_idx == '0) ? ST_IDLE : ST_FCHK;
            end else begin
               rem_in   = elapsed[15:0];
               quo_in   = 16'd0;
               step_in  = 4'd0;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            // one quotient bit per cycle; elapsed < duration keeps it 16 bits
            if (div_ge) begin
               rem_in = 16'(t_div - {1'b0, rd_duration});
            end else begin
               rem_in = t_div[15:0];
            end
            quo_in  = {quo_ff[14:0], div_ge};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = ST_FMUL1;
            end
         end
         ST_FMUL1: state_in = ST_FMUL2;
         ST_FMUL2: state_in = ST_FEXP;
         ST_FEXP:  state_in = ST_FMUL3;
         ST_FMUL3: state_in = ST_FOUT;
         ST_FOUT: begin
            o_valid_in = 1'b1;
            o_last_in  = (rd_idx == '0);
            o_kind_in  = KIND_UPDATE;
            o_tgt_in   = rd_target;
            o_prop_in  = rd_property;
            o_val_in   = upd_value;
            idx_in     = idx_ff - CNT_W'(1);
            state_in   = (rd_idx == '0) ? ST_IDLE : ST_FCHK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      o_last_ff <= o_last_in;
      o_kind_ff <= o_kind_in;
      o_tgt_ff  <= o_tgt_in;
      o_prop_ff <= o_prop_in;
      o_val_ff  <= o_val_in;
      if (accept) begin
         tgt_ff  <= req_target_id;
         prop_ff <= req_property_id;
         cur_ff  <= req_current_value;
         goal_ff <= req_goal_value;
         dur_ff  <= req_duration_ms;
         now_ff  <= req_now_ms;
      end
      if (state_ff == ST_FCHK) begin
         neg_ff <= diff[32];
         mag_ff <= diff[32] ? 34'(-{diff[32], diff}) : {1'b0, diff};
      end
      if (state_ff == ST_FMUL1 || state_ff == ST_FMUL2 || state_ff == ST_FMUL3) begin
         prod_ff <= mul_p;
      end
      if (state_ff == ST_FEXP) begin
         e_ff <= e_diff[48:32];
      end
   end

   // compact on removal, append at the tail
   always_ff @(posedge clock) begin
      for (int j = 0; j < SLOTS; j++) begin
         if (rm_en && IDX_W'(j) >= rd_idx && j < SLOTS - 1) begin
            slot_target_ff[j]   <= slot_target_ff[(j + 1) % SLOTS];
            slot_property_ff[j] <= slot_property_ff[(j + 1) % SLOTS];
            slot_start_ff[j]    <= slot_start_ff[(j + 1) % SLOTS];
            slot_end_ff[j]      <= slot_end_ff[(j + 1) % SLOTS];
            slot_begin_ff[j]    <= slot_begin_ff[(j + 1) % SLOTS];
            slot_duration_ff[j] <= slot_duration_ff[(j + 1) % SLOTS];
         end else if (wr_en && CNT_W'(j) == count_ff) begin
            slot_target_ff[j]   <= tgt_ff;
            slot_property_ff[j] <= prop_ff;
            slot_start_ff[j]    <= cur_ff;
            slot_end_ff[j]      <= goal_ff;
            slot_begin_ff[j]    <= now_ff;
            slot_duration_ff[j] <= dur_ff;
         end
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_kind         = o_kind_ff;
   assign rsp_out_target   = o_tgt_ff;
   assign rsp_out_property = o_prop_ff;
   assign rsp_value        = o_val_ff;
   assign rsp_last         = o_last_ff;
endmodule
`default_nettype wire

// ===== rtl/ett_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ett_checker
   import ett_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_action,
   input wire logic        rsp_valid,
   input wire logic [2:0]  rsp_kind,
   input wire logic [15:0] rsp_out_target,
   input wire logic [7:0]  rsp_out_property,
   input wire logic [31:0] rsp_value,
   input wire logic        rsp_last
);
   a_single_result_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_ACCEPTED || rsp_kind == KIND_FULL ||
                     rsp_kind == KIND_STOPPED || rsp_kind == KIND_EMPTY)) |-> rsp_last)
      else $error("single-result transaction without last");

   a_stop_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_STOPPED) |-> (rsp_out_property == 8'd0 && rsp_value == 32'd0))
      else $error("stopped result carries payload");

   a_empty_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_EMPTY) |-> (rsp_out_target == 16'd0 && rsp_value == 32'd0))
      else $error("frame empty result carries payload");

   a_table_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_ANIMATE || req_action == ACT_STOP)) |=> busy)
      else $error("table command accepted without going busy");
endmodule

bind eased_tween_table_unit ett_checker u_ett_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_action(req_action),
   .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_out_target(rsp_out_target),
   .rsp_out_property(rsp_out_property), .rsp_value(rsp_value), .rsp_last(rsp_last)
);
`default_nettype wire

// ===== tb/tween_checker.sv =====
`timescale 1ns / 1ps
module tween_checker
   import ett_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_target_id,
   input  wire logic [7:0]  req_property_id,
   input  wire logic [31:0] req_current_value,
   input  wire logic [31:0] req_goal_value,
   input  wire logic [15:0] req_duration_ms,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        rsp_valid,
   input  wire logic [2:0]  rsp_kind,
   input  wire logic [15:0] rsp_out_target,
   input  wire logic [7:0]  rsp_out_property,
   input  wire logic [31:0] rsp_value,
   input  wire logic        rsp_last,
   output int               errors,
   output int               pending,
   output int               results_seen
);
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] tgt;
      logic [7:0]  prop;
      logic [31:0] value;
      logic        last;
   } tween_result_type;

   typedef struct packed {
      logic [15:0] tgt;
      logic [7:0]  prop;
      logic [31:0] from_v;
      logic [31:0] to_v;
      logic [31:0] t0;
      logic [15:0] dur;
   } tween_slot_type;

   tween_slot_type   table_q[$];
   tween_result_type expected_results[$];

   assign pending = expected_results.size();

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic logic [31:0] ease_out_cubic(input logic [31:0] s, input logic [31:0] e,
                                                  input logic [31:0] el, input logic [15:0] d);
      logic [63:0] p, q, eased, mag, dd;
      longint diff, delta;
      begin
         p = ({32'd0, el} << 16) / {48'd0, d};
         q = 64'd65536 - p;
         eased = ((64'd1 << 48) - q * q * q) >> 32;
         diff = longint'($signed(e)) - longint'($signed(s));
         mag = diff < 0 ? -diff : diff;
         dd = (mag * eased) >> 16;
         delta = diff < 0 ? -longint'(dd) : longint'(dd);
         return 32'(longint'($signed(s)) + delta);
      end
   endfunction

   task automatic predict_item();
      tween_slot_type ent;
      logic [31:0] el;
      int i;
      begin
         case (req_action)
            ACT_ANIMATE: begin
               for (i = 0; i < table_q.size(); i++)
                  if (table_q[i].tgt == req_target_id && table_q[i].prop == req_property_id) begin
                     table_q.delete(i);
                     break;
                  end
               if (table_q.size() >= SLOTS) begin
                  expected_results.push_back({KIND_FULL, req_target_id, req_property_id,
                                              32'd0, 1'b1});
               end else begin
                  ent = '{req_target_id, req_property_id, req_current_value,
                          req_goal_value, req_now_ms, req_duration_ms};
                  table_q.push_back(ent);
                  expected_results.push_back({KIND_ACCEPTED, req_target_id,
                                              req_property_id, 32'd0, 1'b1});
               end
            end
            ACT_STOP: begin
               for (i = table_q.size() - 1; i >= 0; i--)
                  if (table_q[i].tgt == req_target_id) table_q.delete(i);
               expected_results.push_back({KIND_STOPPED, req_target_id, 8'd0, 32'd0, 1'b1});
            end
            ACT_FRAME: begin
               if (table_q.size() == 0)
                  expected_results.push_back({KIND_EMPTY, 16'd0, 8'd0, 32'd0, 1'b1});
               for (i = table_q.size() - 1; i >= 0; i--) begin
                  ent = table_q[i];
                  el = req_now_ms - ent.t0;
                  if (ent.dur == 0 || el >= {16'd0, ent.dur}) begin
                     expected_results.push_back({KIND_FINISHED, ent.tgt, ent.prop, ent.to_v,
                                                 i == 0});
                     table_q.delete(i);
                  end else begin
                     expected_results.push_back({KIND_UPDATE, ent.tgt, ent.prop,
                        ease_out_cubic(ent.from_v, ent.to_v, el, ent.dur), i == 0});
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin
      tween_result_type want;
      if (reset) begin
         table_q.delete();
         expected_results.delete();
         errors = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d", rsp_kind));
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind || rsp_out_target !== want.tgt ||
                   rsp_out_property !== want.prop || rsp_value !== want.value ||
                   rsp_last !== want.last)
                  report_mismatch($sformatf(
                     "got k%0d t%h p%h v%h l%0d, want k%0d t%h p%h v%h l%0d",
                     rsp_kind, rsp_out_target, rsp_out_property, rsp_value, rsp_last,
                     want.kind, want.tgt, want.prop, want.value, want.last));
            end
         end
         if (start && !busy) predict_item();
      end
   end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import ett_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [15:0] req_target_id;
   logic [7:0]  req_property_id;
   logic signed [31:0] req_current_value;
   logic signed [31:0] req_goal_value;
   logic [15:0] req_duration_ms;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_out_target;
   logic [7:0]  rsp_out_property;
   logic signed [31:0] rsp_value;
   logic        rsp_last;
   int          errors, pending, results_seen;
   int          idle_pct;
   int          sent;
   logic [31:0] clock_ms;

   eased_tween_table_unit DUT (.*);

   tween_checker checker_i (
      .clock, .reset, .start, .busy, .req_action, .req_target_id, .req_property_id,
      .req_current_value, .req_goal_value, .req_duration_ms, .req_now_ms,
      .rsp_valid, .rsp_kind, .rsp_out_target, .rsp_out_property, .rsp_value,
      .rsp_last, .errors, .pending, .results_seen);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // hold one transaction on the ports until it is taken; start stays high
   // after the taking edge, so the caller drives the next transaction or idles
   task automatic send_item(input logic [1:0] act, input logic [15:0] tgt,
                            input logic [7:0] prop, input logic [31:0] cur,
                            input logic [31:0] goal, input logic [15:0] dur,
                            input logic [31:0] now);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_target_id <= tgt;
      req_property_id <= prop;
      req_current_value <= cur;
      req_goal_value <= goal;
      req_duration_ms <= dur;
      req_now_ms <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   task automatic send_random();
      int r;
      logic [15:0] tgt;
      begin
         r = $urandom_range(99);
         tgt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
         clock_ms = clock_ms + $urandom_range(40);
         if (r < 55)
            send_item(ACT_ANIMATE, tgt,
                      ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5)),
                      $urandom, $urandom,
                      ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
                      clock_ms);
         else if (r < 65)
            send_item(ACT_STOP, tgt, 8'($urandom), $urandom, $urandom, 16'($urandom),
                      clock_ms);
         else if (r < 97)
            send_item(ACT_FRAME, 16'($urandom), 8'($urandom), $urandom, $urandom,
                      16'($urandom), ($urandom_range(19) == 0) ? $urandom : clock_ms);
         else
            send_item(2'd3, 16'($urandom), 8'($urandom), $urandom, $urandom,
                      16'($urandom), $urandom);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   initial begin
      int i, ph, guard;
      reset = 1; start = 0; req_action = ACT_FRAME; req_target_id = 0;
      req_property_id = 0; req_current_value = 0; req_goal_value = 0;
      req_duration_ms = 0; req_now_ms = 0;
      idle_pct = 0; sent = 0; clock_ms = 32'd1000;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty frame, extremes, zero duration, clock behind, full, replace
      send_item(ACT_FRAME, 16'hFFFF, 8'hFF, 0, 0, 0, 0);
      send_item(ACT_ANIMATE, 16'hFFFF, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 0);
      send_item(ACT_ANIMATE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd100, 32'hFFFF_FFF0);
      send_item(ACT_ANIMATE, 1, 1, 32'h0001_0000, 32'h0005_0000, 16'd0, 0);
      send_item(ACT_FRAME, 0, 0, 0, 0, 0, 32'h0000_0020);
      send_item(ACT_FRAME, 0, 0, 0, 0, 0, 32'h0000_7FFF);
      send_item(ACT_ANIMATE, 2, 3, 32'h0010_0000, 32'h0000_0000, 16'd50, 32'd500);
      send_item(ACT_FRAME, 0, 0, 0, 0, 0, 32'd400);
      send_item(ACT_STOP, 16'd99, 0, 0, 0, 0, 0);
      send_item(ACT_STOP, 16'hFFFF, 0, 0, 0, 0, 0);
      for (i = 0; i < 17; i++)
         send_item(ACT_ANIMATE, 16'd7, 8'(i), 32'(i) << 16, 32'hFFF0_0000, 16'd1000, 0);
      send_item(ACT_ANIMATE, 16'd7, 8'd3, 0, 32'h0001_0000, 16'd1, 0);
      send_item(2'd3, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(ACT_FRAME, 0, 0, 0, 0, 0, 32'd500);
      send_item(ACT_STOP, 16'd7, 0, 0, 0, 0, 0);
      drain();

      for (ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 0) ? 0 : (ph == 1) ? 77 : (ph == 2) ? 0 : 29;
         for (i = 0; i < 100; i++) send_random();
         drain();
      end

      guard = 0;
      while (pending != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      if (pending != 0) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      $display("covered %0d transactions and %0d results across four idle phases",
               sent, results_seen);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
